@@ hdl/exyz_pkg.sv @@
// Package for the Euler XYZ rotation matrix block: formats, CORDIC constants,
// arctangent table and opcode codes. No dependencies.
`default_nettype none
package exyz_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AtanCount      = 24;
  localparam int ZW             = 34;  // angle in Q.28, |z| < 2^32
  localparam int XW             = 31;  // vector in Q.28, |x|,|y| < 2^29
  localparam logic signed [ZW-1:0] Q28Pi     = ZW'(843314856);
  localparam logic signed [ZW-1:0] Q28HalfPi = ZW'(421657428);
  localparam logic signed [XW-1:0] CordicGain = XW'(163008218);
  localparam logic signed [17:0]   OneQ14    = 18'sd16384;

  typedef enum logic [1:0] {
    OP_ROT    = 2'd0,
    OP_DALPHA = 2'd1,
    OP_DBETA  = 2'd2,
    OP_DGAMMA = 2'd3
  } op_e;

  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(210828714);
      1: r = ZW'(124459457);
      2: r = ZW'(65760959);
      3: r = ZW'(33381290);
      4: r = ZW'(16755422);
      5: r = ZW'(8385879);
      6: r = ZW'(4193963);
      7: r = ZW'(2097109);
      8: r = ZW'(1048571);
      9: r = ZW'(524287);
      default: r = (i < AtanCount) ? (ZW'(1) <<< (28 - i)) : '0;
    endcase
    return r;
  endfunction

  // round Q.28 to Q1.14 (round half up) and clamp to +-1.0
  function automatic logic signed [15:0] round_q14(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    logic signed [XW-14:0] s;
    logic signed [15:0] r;
    t = $signed({v[XW-1], v}) + (XW+1)'(8192);
    s = t[XW:14];
    if (s > 16384) r = 16'sd16384;
    else if (s < -16384) r = -16'sd16384;
    else r = s[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/exyz_cordic.sv @@
// Pipelined rotation-mode CORDIC: one item per cycle while en_i is high, one register per step.
// Depends on exyz_pkg.
`default_nettype none
module exyz_cordic import exyz_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] ang_i,
  output logic signed [15:0]      sin_o,
  output logic signed [15:0]      cos_o
);
  localparam int N = (CordicSteps < AtanCount) ? CordicSteps : AtanCount;

  logic signed [ZW-1:0] z_q [N+1];
  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic                 f_q [N+1];
  logic signed [ZW-1:0] z0;
  logic                 f0;

  always_comb begin
    z0 = ZW'(ang_i) <<< 15;
    f0 = 1'b0;
    if (z0 > Q28HalfPi) begin
      z0 = z0 - Q28Pi;
      f0 = 1'b1;
    end else if (z0 < -Q28HalfPi) begin
      z0 = z0 + Q28Pi;
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= z0;
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      f_q[0] <= f0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q28(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q28(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= round_q14(f_q[N] ? -y_q[N] : y_q[N]);
      cos_o <= round_q14(f_q[N] ? -x_q[N] : x_q[N]);
    end
  end
endmodule
`default_nettype wire

@@ hdl/exyz_matmul.sv @@
// Two-stage product of the three factor matrices with final rounding.
// Depends on exyz_pkg.
`default_nettype none
module exyz_matmul import exyz_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [15:0] sa_i, ca_i, sb_i, cb_i, sg_i, cg_i,
  output logic signed [15:0]      r_o [9]
);
  logic signed [17:0] fx [9], fy [9], fz [9];
  logic signed [17:0] fz_q [9];
  logic signed [33:0] p_q [9];
  logic signed [53:0] acc [9];

  always_comb begin
    if (op_e'(op_i) == OP_DALPHA)
      fx = '{18'sd0, 18'sd0, 18'sd0, 18'sd0, -18'(sa_i), -18'(ca_i),
             18'sd0, 18'(ca_i), -18'(sa_i)};
    else
      fx = '{OneQ14, 18'sd0, 18'sd0, 18'sd0, 18'(ca_i), -18'(sa_i),
             18'sd0, 18'(sa_i), 18'(ca_i)};
    if (op_e'(op_i) == OP_DBETA)
      fy = '{-18'(sb_i), 18'sd0, 18'(cb_i), 18'sd0, 18'sd0, 18'sd0,
             -18'(cb_i), 18'sd0, -18'(sb_i)};
    else
      fy = '{18'(cb_i), 18'sd0, 18'(sb_i), 18'sd0, OneQ14, 18'sd0,
             -18'(sb_i), 18'sd0, 18'(cb_i)};
    if (op_e'(op_i) == OP_DGAMMA)
      fz = '{-18'(sg_i), -18'(cg_i), 18'sd0, 18'(cg_i), -18'(sg_i), 18'sd0,
             18'sd0, 18'sd0, 18'sd0};
    else
      fz = '{18'(cg_i), -18'(sg_i), 18'sd0, 18'(sg_i), 18'(cg_i), 18'sd0,
             18'sd0, 18'sd0, OneQ14};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p_q[i*3+j] <= 34'(fx[i*3] * fy[j]) + 34'(fx[i*3+1] * fy[3+j])
                      + 34'(fx[i*3+2] * fy[6+j]);
      fz_q <= fz;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc[i*3+j] = 54'(p_q[i*3] * fz_q[j]) + 54'(p_q[i*3+1] * fz_q[3+j])
                   + 54'(p_q[i*3+2] * fz_q[6+j]);
  end

  logic signed [53:0] acc_q [9];
  always_ff @(posedge clk_i) begin
    if (en_i) acc_q <= acc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        logic signed [53:0] t;
        logic signed [25:0] s;
        t = acc_q[k] + 54'sd134217728;
        s = t[53:28];
        if (s > 16384) r_o[k] <= 16'sd16384;
        else if (s < -16384) r_o[k] <= -16'sd16384;
        else r_o[k] <= s[15:0];
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/euler_xyz_rotation_matrix_and_partials.sv @@
// Euler XYZ rotation matrix R = Rx*Ry*Rz or a partial of it, per request.
// Throughput one request per cycle when not stalled.
// The pipeline advances whenever the output register is empty or being taken;
// stall_i freezes every stage while the last stage holds a request. Reset (rst_ni low, async) clears valid bits only.
// Depends on exyz_pkg, exyz_cordic, exyz_matmul.
`default_nettype none
module euler_xyz_rotation_matrix_and_partials import exyz_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [15:0] alpha_angle_i,
  input  wire logic signed [15:0] beta_angle_i,
  input  wire logic signed [15:0] gamma_angle_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [15:0]      r00_o, r01_o, r02_o,
  output logic signed [15:0]      r10_o, r11_o, r12_o,
  output logic signed [15:0]      r20_o, r21_o, r22_o
);
  localparam int N   = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
  localparam int Lat = N + 5;

  // whole pipeline moves as one; stalls only when the last stage holds a
  // request the consumer refuses
  logic en;
  logic [Lat-1:0] v_q;
  logic [1:0] op_q [N+2];
  logic signed [15:0] sa, ca, sb, cb, sg, cg;
  logic signed [15:0] r [9];

  assign en      = !(v_q[Lat-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat-2:0], valid_i};
  end

  // opcode rides alongside the CORDIC
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[0] <= opcode_i;
      for (int i = 1; i < N + 2; i++) op_q[i] <= op_q[i-1];
    end
  end

  exyz_cordic #(.CordicSteps(CORDIC_STEPS)) u_ca (
    .clk_i, .en_i(en), .ang_i(alpha_angle_i), .sin_o(sa), .cos_o(ca));
  exyz_cordic #(.CordicSteps(CORDIC_STEPS)) u_cb (
    .clk_i, .en_i(en), .ang_i(beta_angle_i), .sin_o(sb), .cos_o(cb));
  exyz_cordic #(.CordicSteps(CORDIC_STEPS)) u_cg (
    .clk_i, .en_i(en), .ang_i(gamma_angle_i), .sin_o(sg), .cos_o(cg));

  exyz_matmul u_mm (
    .clk_i, .en_i(en), .op_i(op_q[N+1]),
    .sa_i(sa), .ca_i(ca), .sb_i(sb), .cb_i(cb), .sg_i(sg), .cg_i(cg),
    .r_o(r));

  assign r00_o = r[0];
  assign r01_o = r[1];
  assign r02_o = r[2];
  assign r10_o = r[3];
  assign r11_o = r[4];
  assign r12_o = r[5];
  assign r20_o = r[6];
  assign r21_o = r[7];
  assign r22_o = r[8];
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for euler_xyz_rotation_matrix_and_partials.
// Predicts the rotation matrix and its partials with an in-bench CORDIC model.
// Depends on exyz_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;
  import exyz_pkg::*;

  localparam int Steps      = 16;
  localparam int NumRandom  = 1350;
  localparam int WatchLimit = 20000;
  localparam int DrainWait  = 64;

  // one request as driven
  typedef struct {
    op_e                op;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] gamma;
  } angle_req_t;

  typedef logic signed [15:0] elem_t;
  typedef struct {
    elem_t e[9];
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [1:0] opcode_i = '0;
  logic signed [15:0] alpha_angle_i = '0, beta_angle_i = '0, gamma_angle_i = '0;
  logic stall_o, valid_o;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  euler_xyz_rotation_matrix_and_partials #(.CORDIC_STEPS(Steps)) u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i, .alpha_angle_i, .beta_angle_i,
    .gamma_angle_i, .valid_o, .stall_i, .r00_o, .r01_o, .r02_o, .r10_o, .r11_o,
    .r12_o, .r20_o, .r21_o, .r22_o
  );

  always #5 clk_i = ~clk_i;

  matrix_t expected_q[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;  // arithmetic shift is floor division on two's complement
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                        8385879, 4193963, 2097109, 1048571, 524287};
    if (i < 10) return tbl[i];
    return longint'(1) << (28 - i);
  endfunction

  // sine and cosine of a Q3.13 angle, both Q1.14
  task automatic cordic_sin_cos(input logic signed [15:0] ang,
                                output longint s14, output longint c14);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 32768;
    x = 163008218;
    y = 0;
    flip = 1'b0;
    if (z > 421657428) begin
      z -= 843314856;
      flip = 1'b1;
    end else if (z < -421657428) begin
      z += 843314856;
      flip = 1'b1;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y  = y + floor_shr(x, i);
        z -= atan_entry(i);
      end else begin
        nx = x + floor_shr(y, i);
        y  = y - floor_shr(x, i);
        z += atan_entry(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s14 = clamp_unit(floor_shr(y + 8192, 14));
    c14 = clamp_unit(floor_shr(x + 8192, 14));
  endtask

  task automatic predict_matrix(input angle_req_t rq, output matrix_t m);
    longint sa, ca, sb, cb, sg, cg;
    longint fx[9], fy[9], fz[9], p[9], acc;
    cordic_sin_cos(rq.alpha, sa, ca);
    cordic_sin_cos(rq.beta, sb, cb);
    cordic_sin_cos(rq.gamma, sg, cg);
    if (rq.op == OP_DALPHA) fx = '{0, 0, 0, 0, -sa, -ca, 0, ca, -sa};
    else                    fx = '{16384, 0, 0, 0, ca, -sa, 0, sa, ca};
    if (rq.op == OP_DBETA)  fy = '{-sb, 0, cb, 0, 0, 0, -cb, 0, -sb};
    else                    fy = '{cb, 0, sb, 0, 16384, 0, -sb, 0, cb};
    if (rq.op == OP_DGAMMA) fz = '{-sg, -cg, 0, cg, -sg, 0, 0, 0, 0};
    else                    fz = '{cg, -sg, 0, sg, cg, 0, 0, 0, 16384};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += fx[i*3+k] * fy[k*3+j];
        p[i*3+j] = acc;
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += p[i*3+k] * fz[k*3+j];
        m.e[i*3+j] = elem_t'(clamp_unit(floor_shr(acc + (longint'(1) << 27), 28)));
      end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: sampled at the edge, compared against the oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    matrix_t got, want;
    string names[9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
    if (rst_ni && valid_o && !stall_i) begin
      got.e = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      if (expected_q.size() == 0) begin
        $error("unexpected result, nothing pending");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.e[i] !== want.e[i]) begin
            $error("%s mismatch: expected %0d actual %0d", names[i], want.e[i], got.e[i]);
            fail_count++;
          end
      end
    end
  end

  // receiver stall, redrawn every edge
  always @(posedge clk_i)
    stall_i <= ($urandom_range(99) < recv_stall_pct);

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // drive one request and hold it until accepted; the predictor runs on accept.
  // valid stays high on return; the caller lowers it when no request follows.
  task automatic send_request(input angle_req_t rq);
    matrix_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    opcode_i      <= rq.op;
    alpha_angle_i <= rq.alpha;
    beta_angle_i  <= rq.beta;
    gamma_angle_i <= rq.gamma;
    do @(posedge clk_i); while (stall_o);
    predict_matrix(rq, m);
    expected_q.push_back(m);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'((32767 - int'($urandom_range(7))) * ($urandom_range(1) ? 1 : -1));
      1: return 16'($urandom_range(2000)) - 16'sd1000;  // near zero
      default: return 16'($urandom);
    endcase
  endfunction

  // directed rows; expected matrix typed in only for the zero-angle rotation
  angle_req_t directed[$];

  initial begin
    angle_req_t rq;
    matrix_t m;
    int phase_len;
    // zero angles give the identity / simple partial rows
    for (int op = 0; op < 4; op++)
      directed.push_back('{op_e'(op), 16'sd0, 16'sd0, 16'sd0});
    for (int op = 0; op < 4; op++) begin
      directed.push_back('{op_e'(op), 16'sh7fff, -16'sh8000, 16'sh7fff});
      directed.push_back('{op_e'(op), -16'sh8000, 16'sh7fff, -16'sh8000});
      // just past +-pi/2 in Q3.13 (12868) exercises the pi reduction
      directed.push_back('{op_e'(op), 16'sd12868, -16'sd12868, 16'sd12869});
      directed.push_back('{op_e'(op), 16'sd25736, -16'sd25736, 16'sd6434});
    end
    directed.push_back('{OP_ROT, 16'sh5555, 16'shaaaa, 16'sh0001});
    directed.push_back('{OP_DBETA, 16'shaaaa, 16'sh5555, -16'sd1});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling
    foreach (directed[i]) send_request(directed[i]);
    valid_i <= 1'b0;
    // rotation at zero angles must be the identity
    wait (expected_q.size() == 0);
    @(posedge clk_i);
    rq = '{OP_ROT, 16'sd0, 16'sd0, 16'sd0};
    send_request(rq);
    predict_matrix(rq, m);
    for (int i = 0; i < 9; i++)
      if (m.e[i] !== ((i % 4 == 0) ? 16'sd16384 : 16'sd0)) begin
        $error("identity prediction wrong");
        fail_count++;
      end

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 34 : 82) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 34 : 82) : 0;
      phase_len = NumRandom / 4;
      for (int n = 0; n < phase_len; n++) begin
        rq.op    = op_e'($urandom_range(3));
        rq.alpha = rand_angle();
        rq.beta  = rand_angle();
        rq.gamma = rand_angle();
        send_request(rq);
        // one full drain mid-phase
        if (n == phase_len / 2) begin
          valid_i <= 1'b0;
          wait (expected_q.size() == 0);
        end
      end
    end
    valid_i <= 1'b0;
    recv_stall_pct = 0;
    wait (expected_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ euler_xyz_rotation_matrix_and_partials.f @@
hdl/exyz_pkg.sv
hdl/exyz_cordic.sv
hdl/exyz_matmul.sv
hdl/euler_xyz_rotation_matrix_and_partials.sv
tb/sv/tb_top.sv
